[hdl/btpm_pkg.sv]
// Shared types, constants and helper functions of the ballistic true-peak meter.
`default_nettype none

package btpm_pkg;

    localparam int CHANNELS   = 2;
    localparam int MAX_BLOCK  = 4096;
    localparam int CH_W       = 1;
    localparam int SAMPLE_W   = 24;
    localparam int LEVEL_W    = 23;
    localparam int COEF_W     = 24;
    localparam int POW_W      = COEF_W + 1;
    localparam int SUM_W      = 58;
    localparam int LEN_W      = $clog2(MAX_BLOCK + 1);
    localparam int MUL_W      = 26;
    localparam int PROD_W     = 2 * MUL_W;
    localparam int ACC_W      = 34;
    localparam int ROOT_W     = SUM_W / 2;
    localparam int SQREM_W    = ROOT_W + 2;
    localparam int CNT_W      = 6;
    localparam int NUM_CFG    = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int NUM_LEVELS = 3;

    localparam logic [LEVEL_W-1:0] LEVEL_MAX = {LEVEL_W{1'b1}};
    localparam logic [SUM_W-1:0]   SUM_MAX   = {SUM_W{1'b1}};
    localparam logic [POW_W-1:0]   POW_ONE   = POW_W'(1) << COEF_W;
    localparam logic signed [SAMPLE_W-1:0] FULL_SCALE_POS = 24'sd4194304;
    localparam logic signed [SAMPLE_W-1:0] FULL_SCALE_NEG = -24'sd4194304;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PEAK_ATT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PEAK_REL = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RMS_ATT  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RMS_REL  = 2'd3;

    localparam logic [COEF_W-1:0] CFG_RESET [NUM_CFG] =
        '{24'd16733582, 24'd16776342, 24'd16772848, 24'd16776633};

    // smoothed level slots
    localparam logic [1:0] LVL_PEAK = 2'd0;
    localparam logic [1:0] LVL_RMS  = 2'd1;
    localparam logic [1:0] LVL_TRUE = 2'd2;

    localparam logic OP_SAMPLE    = 1'b0;
    localparam logic OP_CLEAR_CLIP = 1'b1;

    typedef struct packed {
        logic                       operation;
        logic [CH_W-1:0]            channel;
        logic signed [SAMPLE_W-1:0] sample;
        logic                       last;
    } req_t;

    typedef struct packed {
        logic [CH_W-1:0]    out_channel;
        logic [LEVEL_W-1:0] peak_level;
        logic [LEVEL_W-1:0] rms_level;
        logic [LEVEL_W-1:0] true_peak_level;
        logic               clip_held;
    } rsp_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_SQ,
        ST_SQACC,
        ST_TMUL,
        ST_TACC,
        ST_TCMP,
        ST_LAST,
        ST_DIV,
        ST_SQRT,
        ST_SMSEL,
        ST_POW,
        ST_POWR,
        ST_POWB,
        ST_POWB2,
        ST_SMMUL,
        ST_SMRES,
        ST_EMIT
    } state_t;

    // Catmull-Rom weights x128 for phase k/4, tap j
    function automatic logic signed [7:0] interp_weight(input logic [1:0] k,
                                                        input logic [1:0] j);
        logic signed [7:0] w;
        case ({k, j})
            4'b01_00: w = -8'sd9;
            4'b01_01: w = 8'sd111;
            4'b01_10: w = 8'sd29;
            4'b01_11: w = -8'sd3;
            4'b10_00: w = -8'sd8;
            4'b10_01: w = 8'sd72;
            4'b10_10: w = 8'sd72;
            4'b10_11: w = -8'sd8;
            4'b11_00: w = -8'sd3;
            4'b11_01: w = 8'sd29;
            4'b11_10: w = 8'sd111;
            4'b11_11: w = -8'sd9;
            default:  w = 8'sd0;
        endcase
        return w;
    endfunction

    // (p + 2^23) >> 24 for a non-negative Q0.24 product
    function automatic logic [POW_W-1:0] round_q24(input logic signed [PROD_W-1:0] p);
        logic [PROD_W-1:0] t;
        t = $unsigned(p) + (PROD_W'(1) << (COEF_W - 1));
        return t[COEF_W +: POW_W];
    endfunction

endpackage

`default_nettype wire

[hdl/btpm_mul.sv]
// Shared signed multiplier with registered product.
`default_nettype none

module btpm_mul (
    input  wire logic                                  clk,
    input  wire logic signed [btpm_pkg::MUL_W-1:0]     a,
    input  wire logic signed [btpm_pkg::MUL_W-1:0]     b,
    output logic signed [btpm_pkg::PROD_W-1:0]         p
);
    import btpm_pkg::*;

    logic signed [PROD_W-1:0] p_reg;

    always_ff @(posedge clk)
    begin
        p_reg <= a * b;
    end

    assign p = p_reg;

endmodule

`default_nettype wire

[hdl/ballistic_true_peak_meter.sv]
// Top level of the ballistic block meter with 4x cubic true-peak estimate.
`default_nettype none

// Two-channel level meter. Each sample item folds into its channel's block
// peak, sum of squares and interpolated true peak; an item flagged last
// closes the block and one result item carries the smoothed levels. All
// multiplies use one shared 26x26 multiplier under a small sequencer,
// and req_stall stays high until the item is done. A sample computes up to
// two interpolated segments. Block end adds a bit-serial divide and square
// root, then for each of the three levels raises the coefficient to the block
// length by square and multiply, then hands over the result, waiting while
// rsp_stall holds a pending result. A clear item is taken without a stall.
// Configuration writes apply at once.
module ballistic_true_peak_meter (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              req_valid,
    output logic                                   req_stall,
    input  wire btpm_pkg::req_t                    req,
    output logic                                   rsp_valid,
    input  wire logic                              rsp_stall,
    output btpm_pkg::rsp_t                         rsp,
    input  wire logic                              cfg_we,
    input  wire logic [btpm_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [btpm_pkg::COEF_W-1:0]       cfg_data
);
    import btpm_pkg::*;

    state_t state_reg, state_next;

    logic [COEF_W-1:0] cfg_reg [NUM_CFG];

    logic [LEVEL_W-1:0] sm_reg   [NUM_LEVELS][CHANNELS];
    logic [LEVEL_W-1:0] sm_next  [NUM_LEVELS][CHANNELS];
    logic [LEVEL_W-1:0] bpk_reg  [CHANNELS];
    logic [LEVEL_W-1:0] bpk_next [CHANNELS];
    logic [LEVEL_W-1:0] btp_reg  [CHANNELS];
    logic [LEVEL_W-1:0] btp_next [CHANNELS];
    logic [SUM_W-1:0]   sum_reg  [CHANNELS];
    logic [SUM_W-1:0]   sum_next [CHANNELS];
    logic [LEN_W-1:0]   len_reg  [CHANNELS];
    logic [LEN_W-1:0]   len_next [CHANNELS];
    logic signed [SAMPLE_W-1:0] older_reg [CHANNELS];
    logic signed [SAMPLE_W-1:0] older_next[CHANNELS];
    logic signed [SAMPLE_W-1:0] rec0_reg  [CHANNELS];
    logic signed [SAMPLE_W-1:0] rec0_next [CHANNELS];
    logic signed [SAMPLE_W-1:0] rec1_reg  [CHANNELS];
    logic signed [SAMPLE_W-1:0] rec1_next [CHANNELS];
    logic [1:0] hcnt_reg   [CHANNELS];
    logic [1:0] hcnt_next  [CHANNELS];
    logic [1:0] hstart_reg [CHANNELS];
    logic [1:0] hstart_next[CHANNELS];
    logic [1:0] phase_reg  [CHANNELS];
    logic [1:0] phase_next [CHANNELS];
    logic clip_reg, clip_next;

    logic [CH_W-1:0] ch_reg, ch_next;
    logic last_reg, last_next;
    logic signed [SAMPLE_W-1:0] x_reg, x_next;
    logic signed [SAMPLE_W-1:0] tap_reg  [2][4];
    logic signed [SAMPLE_W-1:0] tap_next [2][4];
    logic [1:0] seg_en_reg, seg_en_next;
    logic seg_reg, seg_next;
    logic [1:0] k_reg, k_next;
    logic [1:0] j_reg, j_next;
    logic signed [ACC_W-1:0] acc_reg, acc_next;
    logic [SUM_W-1:0] dvd_reg, dvd_next;
    logic [SQREM_W-1:0] rem_reg, rem_next;
    logic [ROOT_W-1:0] root_reg, root_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [LEN_W-1:0] n_reg, n_next;
    logic [LEN_W-1:0] nsh_reg, nsh_next;
    logic [POW_W-1:0] pr_reg, pr_next;
    logic [POW_W-1:0] pb_reg, pb_next;
    logic [1:0] lvl_reg, lvl_next;
    logic [LEVEL_W-1:0] rmst_reg, rmst_next;
    rsp_t out_reg, out_next;
    logic out_valid_reg, out_valid_next;

    logic signed [MUL_W-1:0] mul_a, mul_b;
    logic signed [PROD_W-1:0] prod;

    // helpers
    logic [1:0] a_k, a_hs;
    logic signed [SAMPLE_W-1:0] a_x;
    logic [SAMPLE_W:0] a_abs;
    logic [LEVEL_W-1:0] a_mag;
    logic [SUM_W:0] sq_sum;
    logic [ACC_W-1:0] acc_abs;
    logic [ACC_W-1:0] acc_rnd;
    logic [LEVEL_W-1:0] tp_mag;
    logic [LEN_W:0] div_rem_sh;
    logic [SQREM_W+1:0] sq_rem_sh, sq_trial;
    logic [LEVEL_W-1:0] cur_lvl, tgt_lvl, diff_lvl;
    logic [COEF_W-1:0] att_c, rel_c;
    logic [POW_W-1:0] m_val;
    logic [POW_W:0] res_val;
    logic emit_ok;

    btpm_mul u_mul (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (prod)
    );

    // current and target of the level being smoothed
    always_comb
    begin
        cur_lvl = sm_reg[lvl_reg][ch_reg];
        case (lvl_reg)
            LVL_PEAK: tgt_lvl = bpk_reg[ch_reg];
            LVL_RMS:  tgt_lvl = rmst_reg;
            default:  tgt_lvl = (btp_reg[ch_reg] > bpk_reg[ch_reg]) ?
                                btp_reg[ch_reg] : bpk_reg[ch_reg];
        endcase
        diff_lvl = (cur_lvl >= tgt_lvl) ? cur_lvl - tgt_lvl : tgt_lvl - cur_lvl;
        att_c = (lvl_reg == LVL_RMS) ? cfg_reg[CFG_RMS_ATT] : cfg_reg[CFG_PEAK_ATT];
        rel_c = (lvl_reg == LVL_RMS) ? cfg_reg[CFG_RMS_REL] : cfg_reg[CFG_PEAK_REL];
    end

    assign emit_ok = !out_valid_reg || !rsp_stall;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid && req.operation == OP_SAMPLE)
                begin
                    state_next = ST_SQ;
                end
            end
            ST_SQ:    state_next = ST_SQACC;
            ST_SQACC: state_next = (seg_en_reg != 2'b00) ? ST_TMUL : ST_LAST;
            ST_TMUL:  state_next = ST_TACC;
            ST_TACC:  state_next = (j_reg == 2'd3) ? ST_TCMP : ST_TMUL;
            ST_TCMP:
            begin
                if (k_reg != 2'd3 || (!seg_reg && seg_en_reg[1]))
                begin
                    state_next = ST_TMUL;
                end
                else
                begin
                    state_next = ST_LAST;
                end
            end
            ST_LAST:  state_next = last_reg ? ST_DIV : ST_IDLE;
            ST_DIV:   state_next = (cnt_reg == CNT_W'(SUM_W - 1)) ? ST_SQRT : ST_DIV;
            ST_SQRT:  state_next = (cnt_reg == CNT_W'(ROOT_W - 1)) ? ST_SMSEL : ST_SQRT;
            ST_SMSEL: state_next = ST_POW;
            ST_POW:
            begin
                if (nsh_reg == '0)
                begin
                    state_next = ST_SMMUL;
                end
                else if (nsh_reg[0])
                begin
                    state_next = ST_POWR;
                end
                else
                begin
                    state_next = ST_POWB;
                end
            end
            ST_POWR:  state_next = ST_POWB;
            ST_POWB:  state_next = ST_POWB2;
            ST_POWB2: state_next = ST_POW;
            ST_SMMUL: state_next = ST_SMRES;
            ST_SMRES: state_next = (lvl_reg == LVL_TRUE) ? ST_EMIT : ST_SMSEL;
            ST_EMIT:  state_next = emit_ok ? ST_IDLE : ST_EMIT;
            default:  state_next = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        sm_next = sm_reg;
        bpk_next = bpk_reg;
        btp_next = btp_reg;
        sum_next = sum_reg;
        len_next = len_reg;
        older_next = older_reg;
        rec0_next = rec0_reg;
        rec1_next = rec1_reg;
        hcnt_next = hcnt_reg;
        hstart_next = hstart_reg;
        phase_next = phase_reg;
        clip_next = clip_reg;
        ch_next = ch_reg;
        last_next = last_reg;
        x_next = x_reg;
        tap_next = tap_reg;
        seg_en_next = seg_en_reg;
        seg_next = seg_reg;
        k_next = k_reg;
        j_next = j_reg;
        acc_next = acc_reg;
        dvd_next = dvd_reg;
        rem_next = rem_reg;
        root_next = root_reg;
        cnt_next = cnt_reg;
        n_next = n_reg;
        nsh_next = nsh_reg;
        pr_next = pr_reg;
        pb_next = pb_reg;
        lvl_next = lvl_reg;
        rmst_next = rmst_reg;
        out_next = out_reg;
        out_valid_next = out_valid_reg && rsp_stall;
        mul_a = '0;
        mul_b = '0;
        req_stall = (state_reg != ST_IDLE);

        a_x = req.sample;
        a_k = phase_reg[req.channel];
        a_hs = (a_k == 2'd0) ? hcnt_reg[req.channel] : hstart_reg[req.channel];
        a_abs = a_x[SAMPLE_W-1] ? -{a_x[SAMPLE_W-1], a_x} : {a_x[SAMPLE_W-1], a_x};
        a_mag = (a_abs > (SAMPLE_W+1)'(LEVEL_MAX)) ? LEVEL_MAX : a_abs[LEVEL_W-1:0];

        sq_sum = {1'b0, sum_reg[ch_reg]} + (SUM_W+1)'(prod[2*SAMPLE_W-1:0]);

        acc_abs = acc_reg[ACC_W-1] ? $unsigned(-acc_reg) : $unsigned(acc_reg);
        acc_rnd = (acc_abs + ACC_W'(64)) >> 7;
        tp_mag = (acc_rnd > ACC_W'(LEVEL_MAX)) ? LEVEL_MAX : acc_rnd[LEVEL_W-1:0];

        div_rem_sh = {rem_reg[LEN_W-1:0], dvd_reg[SUM_W-1]};

        sq_rem_sh = {rem_reg, dvd_reg[SUM_W-1 -: 2]};
        sq_trial = (SQREM_W+2)'({root_reg, 2'b01});

        m_val = round_q24(prod);
        res_val = (cur_lvl >= tgt_lvl) ? (POW_W+1)'(tgt_lvl) + (POW_W+1)'(m_val)
                                       : (POW_W+1)'(tgt_lvl) - (POW_W+1)'(m_val);

        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    if (req.operation == OP_CLEAR_CLIP)
                    begin
                        clip_next = 1'b0;
                    end
                    else
                    begin
                        if (a_x >= FULL_SCALE_POS || a_x <= FULL_SCALE_NEG)
                        begin
                            clip_next = 1'b1;
                        end
                        ch_next = req.channel;
                        last_next = req.last;
                        x_next = a_x;
                        hstart_next[req.channel] = a_hs;
                        if (a_mag > bpk_reg[req.channel])
                        begin
                            bpk_next[req.channel] = a_mag;
                        end
                        if (len_reg[req.channel] < LEN_W'(MAX_BLOCK))
                        begin
                            len_next[req.channel] = len_reg[req.channel] + 1'b1;
                        end
                        // segment ending at this sample
                        seg_en_next[0] = (a_k == 2'd1 && a_hs == 2'd2) || a_k[1];
                        tap_next[0][0] = (a_k == 2'd3 || a_hs != 2'd0) ?
                                         older_reg[req.channel] : rec0_reg[req.channel];
                        tap_next[0][1] = rec0_reg[req.channel];
                        tap_next[0][2] = rec1_reg[req.channel];
                        tap_next[0][3] = a_x;
                        // block-end segment with far neighbour clamped
                        seg_en_next[1] = req.last &&
                                         ((a_k == 2'd0 && a_hs == 2'd2) || a_k != 2'd0);
                        tap_next[1][0] = (a_k != 2'd1 || a_hs != 2'd0) ?
                                         rec0_reg[req.channel] : rec1_reg[req.channel];
                        tap_next[1][1] = rec1_reg[req.channel];
                        tap_next[1][2] = a_x;
                        tap_next[1][3] = a_x;
                        older_next[req.channel] = rec0_reg[req.channel];
                        rec0_next[req.channel] = rec1_reg[req.channel];
                        rec1_next[req.channel] = a_x;
                        if (hcnt_reg[req.channel] != 2'd2)
                        begin
                            hcnt_next[req.channel] = hcnt_reg[req.channel] + 1'b1;
                        end
                        if (a_k != 2'd3)
                        begin
                            phase_next[req.channel] = a_k + 1'b1;
                        end
                    end
                end
            end
            ST_SQ:
            begin
                mul_a = MUL_W'(x_reg);
                mul_b = MUL_W'(x_reg);
            end
            ST_SQACC:
            begin
                sum_next[ch_reg] = (sq_sum > (SUM_W+1)'(SUM_MAX)) ? SUM_MAX
                                                                 : sq_sum[SUM_W-1:0];
                seg_next = !seg_en_reg[0];
                k_next = 2'd1;
                j_next = 2'd0;
                acc_next = '0;
            end
            ST_TMUL:
            begin
                mul_a = MUL_W'(interp_weight(k_reg, j_reg));
                mul_b = MUL_W'(tap_reg[seg_reg][j_reg]);
            end
            ST_TACC:
            begin
                acc_next = acc_reg + $signed(prod[ACC_W-1:0]);
                j_next = j_reg + 1'b1;
            end
            ST_TCMP:
            begin
                if (tp_mag > btp_reg[ch_reg])
                begin
                    btp_next[ch_reg] = tp_mag;
                end
                j_next = 2'd0;
                acc_next = '0;
                if (k_reg != 2'd3)
                begin
                    k_next = k_reg + 1'b1;
                end
                else
                begin
                    k_next = 2'd1;
                    seg_next = 1'b1;
                end
            end
            ST_LAST:
            begin
                n_next = (len_reg[ch_reg] == '0) ? LEN_W'(1) : len_reg[ch_reg];
                dvd_next = sum_reg[ch_reg];
                rem_next = '0;
                cnt_next = '0;
            end
            ST_DIV:
            begin
                // restoring divide, one quotient bit a cycle
                if (div_rem_sh >= {1'b0, n_reg})
                begin
                    rem_next = SQREM_W'(div_rem_sh - {1'b0, n_reg});
                    dvd_next = {dvd_reg[SUM_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = SQREM_W'(div_rem_sh);
                    dvd_next = {dvd_reg[SUM_W-2:0], 1'b0};
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(SUM_W - 1))
                begin
                    rem_next = '0;
                    root_next = '0;
                    cnt_next = '0;
                end
            end
            ST_SQRT:
            begin
                // square root, one result bit a cycle
                if (sq_rem_sh >= sq_trial)
                begin
                    rem_next = SQREM_W'(sq_rem_sh - sq_trial);
                    root_next = {root_reg[ROOT_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = SQREM_W'(sq_rem_sh);
                    root_next = {root_reg[ROOT_W-2:0], 1'b0};
                end
                dvd_next = {dvd_reg[SUM_W-3:0], 2'b00};
                cnt_next = cnt_reg + 1'b1;
                rmst_next = (root_next > ROOT_W'(LEVEL_MAX)) ? LEVEL_MAX
                                                             : root_next[LEVEL_W-1:0];
                lvl_next = LVL_PEAK;
            end
            ST_SMSEL:
            begin
                pr_next = POW_ONE;
                pb_next = POW_W'((tgt_lvl > cur_lvl) ? att_c : rel_c);
                nsh_next = n_reg;
            end
            ST_POW:
            begin
                mul_a = MUL_W'(pr_reg);
                mul_b = MUL_W'(pb_reg);
            end
            ST_POWR:
            begin
                pr_next = round_q24(prod);
            end
            ST_POWB:
            begin
                mul_a = MUL_W'(pb_reg);
                mul_b = MUL_W'(pb_reg);
            end
            ST_POWB2:
            begin
                pb_next = round_q24(prod);
                nsh_next = nsh_reg >> 1;
            end
            ST_SMMUL:
            begin
                mul_a = MUL_W'(diff_lvl);
                mul_b = MUL_W'(pr_reg);
            end
            ST_SMRES:
            begin
                sm_next[lvl_reg][ch_reg] = (res_val > (POW_W+1)'(LEVEL_MAX)) ? LEVEL_MAX
                                           : res_val[LEVEL_W-1:0];
                lvl_next = lvl_reg + 1'b1;
            end
            ST_EMIT:
            begin
                if (emit_ok)
                begin
                    out_next.out_channel = ch_reg;
                    out_next.peak_level = sm_reg[LVL_PEAK][ch_reg];
                    out_next.rms_level = sm_reg[LVL_RMS][ch_reg];
                    out_next.true_peak_level = sm_reg[LVL_TRUE][ch_reg];
                    out_next.clip_held = clip_reg;
                    out_valid_next = 1'b1;
                    bpk_next[ch_reg] = '0;
                    btp_next[ch_reg] = '0;
                    sum_next[ch_reg] = '0;
                    len_next[ch_reg] = '0;
                    phase_next[ch_reg] = 2'd0;
                end
            end
            default:
            begin
                req_stall = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            for (int i = 0; i < NUM_CFG; i++)
            begin
                cfg_reg[i] <= CFG_RESET[i];
            end
            for (int c = 0; c < CHANNELS; c++)
            begin
                for (int l = 0; l < NUM_LEVELS; l++)
                begin
                    sm_reg[l][c] <= '0;
                end
                bpk_reg[c] <= '0;
                btp_reg[c] <= '0;
                sum_reg[c] <= '0;
                len_reg[c] <= '0;
                older_reg[c] <= '0;
                rec0_reg[c] <= '0;
                rec1_reg[c] <= '0;
                hcnt_reg[c] <= '0;
                hstart_reg[c] <= '0;
                phase_reg[c] <= '0;
            end
            clip_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            seg_en_reg <= '0;
            seg_reg <= 1'b0;
            k_reg <= '0;
            j_reg <= '0;
            cnt_reg <= '0;
            lvl_reg <= '0;
            nsh_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                cfg_reg[cfg_index] <= cfg_data;
            end
            sm_reg <= sm_next;
            bpk_reg <= bpk_next;
            btp_reg <= btp_next;
            sum_reg <= sum_next;
            len_reg <= len_next;
            older_reg <= older_next;
            rec0_reg <= rec0_next;
            rec1_reg <= rec1_next;
            hcnt_reg <= hcnt_next;
            hstart_reg <= hstart_next;
            phase_reg <= phase_next;
            clip_reg <= clip_next;
            out_valid_reg <= out_valid_next;
            seg_en_reg <= seg_en_next;
            seg_reg <= seg_next;
            k_reg <= k_next;
            j_reg <= j_next;
            cnt_reg <= cnt_next;
            lvl_reg <= lvl_next;
            nsh_reg <= nsh_next;
        end
    end

    // working payload
    always_ff @(posedge clk)
    begin
        ch_reg <= ch_next;
        last_reg <= last_next;
        x_reg <= x_next;
        tap_reg <= tap_next;
        acc_reg <= acc_next;
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        root_reg <= root_next;
        n_reg <= n_next;
        pr_reg <= pr_next;
        pb_reg <= pb_next;
        rmst_reg <= rmst_next;
        out_reg <= out_next;
    end

    assign rsp_valid = out_valid_reg;
    assign rsp = out_reg;

endmodule

`default_nettype wire
